### hdl/fwl_pkg.sv
// Shared types and codes for the FIFO wait list with removal by key.
// No dependencies; used by the top level and its checker.
package fwl_pkg;

    localparam int PID_W  = 8;  // process_id / popped_id field width
    localparam int OCC_W  = 4;  // occupancy field width
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_REMOVE = 2'd2
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

endpackage

### hdl/fifo_wait_list_with_removal_unit.sv
// Push, failed requests and the unused code pass from accept to S_DONE and then to the result register.
// Pop and remove scan the entry memory one word a cycle, then shift the tail forward one
// word a cycle, and then pass through S_DONE to the result register.
// One request is in flight at a time; a new word is taken once the result is latched.
// Reset (rst_n low, asynchronous) empties the list; entry memory contents are not cleared.
// Depends on fwl_pkg.
module fifo_wait_list_with_removal_unit #(
    parameter int DEPTH    = 8,
    parameter int ID_WIDTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] process_id
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] popped_id, [11:8] occupancy, [15:12] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } state_t;

    // entry memory
    logic [ID_WIDTH-1:0] mem [DEPTH];
    logic                rd_en;
    logic [IW-1:0]       rd_addr;
    logic [ID_WIDTH-1:0] rd_data_reg;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic [ID_WIDTH-1:0] wr_data;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [ID_WIDTH-1:0]   id_reg, id_next;
    logic                  pop_reg, pop_next;
    fwl_pkg::status_t      res_status_reg, res_status_next;
    logic [ID_WIDTH-1:0]   res_popped_reg, res_popped_next;
    logic                  m_valid_reg, m_valid_next;
    fwl_pkg::status_t      m_status_reg, m_status_next;
    logic [7:0]            m_popped_reg, m_popped_next;
    logic [3:0]            m_occ_reg, m_occ_next;

    logic                  accept;
    logic [ID_WIDTH+7:0]   id_wide;
    logic [ID_WIDTH-1:0]   in_id;
    logic [ID_WIDTH+7:0]   popped_wide;
    logic [CW+3:0]         occ_wide;
    logic [CW-1:0]         cnt_m1;
    logic [CW-1:0]         idx_ext;
    logic [CW-1:0]         idx_p1;
    logic [CW-1:0]         idx_p2;
    logic                  hit;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // take the id modulo 2^ID_WIDTH, and the popped id modulo 2^8
    assign id_wide     = {{ID_WIDTH{1'b0}}, s_tdata};
    assign in_id       = id_wide[ID_WIDTH-1:0];
    assign popped_wide = {8'd0, res_popped_reg};
    assign occ_wide    = {4'd0, count_reg};

    assign cnt_m1  = count_reg - CW'(1);
    assign idx_ext = CW'(idx_reg);
    assign idx_p1  = idx_ext + CW'(1);
    assign idx_p2  = idx_ext + CW'(2);
    assign hit     = pop_reg || (rd_data_reg == id_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        id_next         = id_reg;
        pop_next        = pop_reg;
        res_status_next = res_status_reg;
        res_popped_next = res_popped_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_popped_next   = m_popped_reg;
        m_occ_next      = m_occ_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = rd_data_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    id_next         = in_id;
                    pop_next        = (s_tuser == fwl_pkg::REQ_POP);
                    res_popped_next = '0;
                    res_status_next = fwl_pkg::ST_OK;
                    state_next      = S_DONE;
                    case (s_tuser)
                        fwl_pkg::REQ_PUSH:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                res_status_next = fwl_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[IW-1:0];
                                wr_data    = in_id;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        fwl_pkg::REQ_POP, fwl_pkg::REQ_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = (s_tuser == fwl_pkg::REQ_POP) ?
                                                  fwl_pkg::ST_EMPTY : fwl_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                idx_next   = '0;
                                state_next = S_SEARCH;
                            end
                        end
                        default:
                        begin
                            res_status_next = fwl_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                // rd_data_reg holds the entry at idx_reg
                if (hit)
                begin
                    if (pop_reg)
                    begin
                        res_popped_next = rd_data_reg;
                    end
                    res_status_next = fwl_pkg::ST_OK;
                    if (idx_ext < cnt_m1)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = idx_p1[IW-1:0];
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        count_next = cnt_m1;
                        state_next = S_DONE;
                    end
                end
                else if (idx_ext < cnt_m1)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_p1[IW-1:0];
                    idx_next = idx_p1[IW-1:0];
                end
                else
                begin
                    res_status_next = fwl_pkg::ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
            end
            S_SHIFT:
            begin
                // rd_data_reg holds entry idx_reg+1; move it down into idx_reg
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data_reg;
                if (idx_p1 < cnt_m1)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_p2[IW-1:0];
                    idx_next = idx_p1[IW-1:0];
                end
                else
                begin
                    count_next = cnt_m1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_popped_next = popped_wide[7:0];
                    m_occ_next    = occ_wide[3:0];
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        id_reg         <= id_next;
        pop_reg        <= pop_next;
        res_status_reg <= res_status_next;
        res_popped_reg <= res_popped_next;
        m_status_reg   <= m_status_next;
        m_popped_reg   <= m_popped_next;
        m_occ_reg      <= m_occ_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {4'd0, m_occ_reg, m_popped_reg};

endmodule

### hdl/fwl_checker.sv
// Port-level checks for the FIFO wait list with removal by key.
// Depends on fwl_pkg; bound to fifo_wait_list_with_removal_unit.
module fwl_port_checker #(
    parameter int DEPTH = 8
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    localparam logic [3:0] FULL_OCC = 4'(DEPTH % 16);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // one request in flight: input closes right after a word is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a request is in flight");

    // only a successful pop carries an id
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != fwl_pkg::ST_OK) |-> (m_tdata[7:0] == 8'd0))
        else $error("popped id set on a failed request");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == fwl_pkg::ST_EMPTY) |-> (m_tdata[11:8] == 4'd0))
        else $error("empty status with nonzero occupancy");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == fwl_pkg::ST_FULL) |-> (m_tdata[11:8] == FULL_OCC))
        else $error("full status with occupancy below capacity");

endmodule

bind fifo_wait_list_with_removal_unit fwl_port_checker #(.DEPTH(DEPTH)) u_fwl_checker (.*);

### tb/fwl_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the FIFO wait list: watches the request and result streams,
// keeps its own copy of the list and checks every result word against it.
// Depends on fwl_pkg.
module fwl_checker #(
    parameter int DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] process_id
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [7:0] popped_id, [11:8] occupancy, [15:12] zero
    input  logic [1:0]  m_tuser,   // [1:0] status
    output int          mismatches,
    output int          results_due
);

    typedef struct packed {
        fwl_pkg::status_t          status;
        logic [fwl_pkg::PID_W-1:0] popped;
        logic [fwl_pkg::OCC_W-1:0] occ;
    } wl_result_t;

    logic [fwl_pkg::PID_W-1:0] list_ids [DEPTH];
    int                        list_fill;
    wl_result_t                due_results [$];

    // Apply one request to the shadow list and return the word it should produce.
    function automatic wl_result_t serve_request(logic [fwl_pkg::REQ_W-1:0] kind,
                                                 logic [fwl_pkg::PID_W-1:0] pid);
        wl_result_t res;
        bit         found;
        res.status = fwl_pkg::ST_OK;
        res.popped = '0;
        found      = 1'b0;
        if (kind == fwl_pkg::REQ_PUSH)
        begin
            if (list_fill >= DEPTH)
            begin
                res.status = fwl_pkg::ST_FULL;
            end
            else
            begin
                list_ids[list_fill] = pid;
                list_fill++;
            end
        end
        else if (kind == fwl_pkg::REQ_POP)
        begin
            if (list_fill == 0)
            begin
                res.status = fwl_pkg::ST_EMPTY;
            end
            else
            begin
                res.popped = list_ids[0];
                for (int k = 1; k < list_fill; k++)
                begin
                    list_ids[k-1] = list_ids[k];
                end
                list_fill--;
            end
        end
        else if (kind == fwl_pkg::REQ_REMOVE)
        begin
            res.status = fwl_pkg::ST_NOT_FOUND;
            // drop the first match from the head, then pull the rest forward
            for (int k = 0; k < list_fill; k++)
            begin
                if (found)
                begin
                    list_ids[k-1] = list_ids[k];
                end
                else if (list_ids[k] == pid)
                begin
                    found      = 1'b1;
                    res.status = fwl_pkg::ST_OK;
                end
            end
            if (found)
            begin
                list_fill--;
            end
        end
        res.occ = list_fill[fwl_pkg::OCC_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        wl_result_t got;
        wl_result_t want;
        if (!rst_n)
        begin
            list_fill = 0;
            due_results.delete();
            mismatches  = 0;
            results_due = 0;
        end
        else
        begin
            // a result leaving at this edge belongs to an earlier request
            if (m_tvalid && m_tready)
            begin
                got = {fwl_pkg::status_t'(m_tuser), m_tdata[7:0], m_tdata[11:8]};
                if (due_results.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("%0t: unexpected result word: status %0d popped %h occ %0d",
                                 $realtime, got.status, got.popped, got.occ);
                    end
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got !== want || m_tdata[15:12] !== 4'd0)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: result mismatch: expected status %0d popped %h occ %0d",
                                     $realtime, want.status, want.popped, want.occ);
                            $display("    got status %0d popped %h occ %0d pad %h",
                                     got.status, got.popped, got.occ, m_tdata[15:12]);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                due_results.push_back(serve_request(s_tuser, s_tdata));
            end
            results_due = due_results.size();
        end
    end

endmodule

### tb/fifo_wait_list_with_removal_unit_tb.sv
`timescale 1ns / 100ps
// Top of the FIFO wait list regression: clock, reset, request stimulus, result-side
// stalls and the verdict. Depends on fwl_pkg, the unit and fwl_checker.
module fifo_wait_list_with_removal_unit_tb;
    import fwl_pkg::*;

    localparam int               DEPTH        = 8;
    localparam int               RANDOM_ITEMS = 600;
    localparam int               HOLD_CYCLES  = 150;
    localparam int               IDLE_LIMIT   = 2000;
    localparam int               DRAIN_CYCLES = 20;
    localparam logic [REQ_W-1:0] REQ_UNUSED   = 2'd3;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] process_id
    logic [1:0]  s_tuser;   // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] popped_id, [11:8] occupancy, [15:12] zero
    logic [1:0]  m_tuser;   // [1:0] status

    int fail_count;
    int results_due;
    int burst_left;
    int idle_cycles;
    bit hold_req;
    bit hold_done;

    fifo_wait_list_with_removal_unit #(
        .DEPTH    (DEPTH),
        .ID_WIDTH (PID_W)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    fwl_checker #(
        .DEPTH (DEPTH)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (fail_count),
        .results_due (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offer one word and hold it until taken; close a burst with a random gap.
    task automatic offer_request(input logic [REQ_W-1:0] kind, input logic [PID_W-1:0] pid);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= pid;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 12);
        end
    endtask

    initial
    begin
        int               push_pct;
        int               pick;
        logic [REQ_W-1:0] kind;
        logic [PID_W-1:0] pid;
        rst_n      = 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= '0;
        s_tdata   <= '0;
        burst_left = 4;
        hold_req   = 1'b0;
        push_pct   = 50;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // empty list: pop, remove and the unused code
        offer_request(REQ_POP,    8'hA5);
        offer_request(REQ_REMOVE, 8'h00);
        offer_request(REQ_UNUSED, 8'hFF);
        // fill to capacity with a duplicate id in the middle, push once more on the full list, then the unused code
        offer_request(REQ_PUSH,   8'h00);
        offer_request(REQ_PUSH,   8'hFF);
        offer_request(REQ_PUSH,   8'h11);
        offer_request(REQ_PUSH,   8'h22);
        offer_request(REQ_PUSH,   8'h33);
        offer_request(REQ_PUSH,   8'h22);
        offer_request(REQ_PUSH,   8'h44);
        offer_request(REQ_PUSH,   8'h55);
        offer_request(REQ_PUSH,   8'h66);
        offer_request(REQ_UNUSED, 8'h5A);
        // remove the first duplicate, the tail, the head, then a missing id
        offer_request(REQ_REMOVE, 8'h22);
        offer_request(REQ_REMOVE, 8'h55);
        offer_request(REQ_REMOVE, 8'h00);
        offer_request(REQ_REMOVE, 8'h99);
        // drain by pops past empty
        offer_request(REQ_POP,    8'h00);
        offer_request(REQ_POP,    8'hFF);
        offer_request(REQ_POP,    8'h3C);
        offer_request(REQ_POP,    8'hC3);
        offer_request(REQ_POP,    8'h01);
        offer_request(REQ_POP,    8'h80);
        // single entry emptied by remove
        offer_request(REQ_PUSH,   8'h5A);
        offer_request(REQ_REMOVE, 8'h5A);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // shift the push/pop balance so the list swings between empty and full
            if (n % 32 == 0) begin
                push_pct = $urandom_range(15, 85);
            end
            if (n == 200) begin
                hold_req = 1'b1;
            end
            pick = $urandom_range(0, 99);
            // mostly a small id pool so removes hit and duplicates occur
            pid  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
            if (pick < 3) begin
                kind = REQ_UNUSED;
            end
            else if ($urandom_range(0, 99) < push_pct) begin
                kind = REQ_PUSH;
            end
            else if ($urandom_range(0, 1) == 0) begin
                kind = REQ_POP;
            end
            else begin
                kind = REQ_REMOVE;
            end
            offer_request(kind, pid);
        end
        s_tvalid <= 1'b0;

        while (results_due != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && results_due == 0) begin
            $display("fifo_wait_list_with_removal_unit regression: pass");
        end
        else begin
            $display("fifo_wait_list_with_removal_unit regression: fail");
        end
        $finish;
    end

    // Result-side stalls: phases of open, random and periodic ready, plus one long hold.
    initial
    begin
        rx_mode_t mode;
        int       span;
        int       tick;
        m_tready <= 1'b0;
        hold_done = 1'b0;
        tick      = 0;
        @(posedge rst_n);
        forever begin
            mode = rx_mode_t'($urandom_range(0, 2));
            span = $urandom_range(30, 200);
            repeat (span) begin
                @(negedge clk);
                if (hold_req && !hold_done) begin
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                    hold_done = 1'b1;
                end
                tick++;
                case (mode)
                    RX_OPEN:     m_tready <= 1'b1;
                    RX_RANDOM:   m_tready <= ($urandom_range(0, 99) < 70);
                    RX_PERIODIC: m_tready <= (tick % 3 == 0);
                    default:     m_tready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("fifo_wait_list_with_removal_unit regression: fail");
                $finish;
            end
        end
    end

endmodule
